// ===== rtl/core/rgb_ycbcr_color_convert_macros.svh =====
// ----------------------------------------------------------------------------
// rgb_ycbcr_color_convert_macros.svh
// Assertion macros for the colour conversion block. Both forms sample on
// the rising edge of clk_i and are disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef RGB_YCBCR_COLOR_CONVERT_MACROS_SVH
`define RGB_YCBCR_COLOR_CONVERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define RYCC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define RYCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RYCC_ASSERT_SAME(lbl, ante, cons, msg)
`define RYCC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/rycc_pkg.sv =====
// ----------------------------------------------------------------------------
// rycc_pkg
// Shared types and constants of the RGB/YCbCr colour conversion block.
// ----------------------------------------------------------------------------
`default_nettype none

package rycc_pkg;

  // Default number of fraction bits of the fixed-point coefficients.
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Headroom of the sums above the fraction bits, sign included.
  localparam int unsigned SUM_EXTRA = 11;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned OPND_W = PIX_W + 1;

  // Configuration port: byte address bits and register index bits.
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned REG_IDX_W = ADDR_W - 2;
  localparam int unsigned DATA_W    = 32;

  localparam logic [REG_IDX_W-1:0] REG_DIRECTION = '0;

  // Chroma midpoint removed from Cb and Cr in the inverse direction.
  localparam logic signed [OPND_W-1:0] CHROMA_MID = 9'sd128;

  typedef enum logic {
    DIR_FWD = 1'b0,
    DIR_INV = 1'b1
  } dir_e;

  // Load enables of the four pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_load_t;

  // First-stage word: the three signed operands and the direction they go with.
  typedef struct packed {
    dir_e                     dir;
    logic signed [OPND_W-1:0] x0;
    logic signed [OPND_W-1:0] x1;
    logic signed [OPND_W-1:0] x2;
  } opnd_t;

endpackage

`default_nettype wire

// ===== rtl/core/rycc_in_if.sv =====
// ----------------------------------------------------------------------------
// rycc_in_if
// Pixel input channel: valid/ready handshake with three 8-bit components.
// ----------------------------------------------------------------------------
`default_nettype none

interface rycc_in_if;

  logic       valid;
  logic       ready;
  logic [7:0] comp_first;
  logic [7:0] comp_second;
  logic [7:0] comp_third;

  modport source (
    output valid,
    output comp_first,
    output comp_second,
    output comp_third,
    input  ready
  );

  modport sink (
    input  valid,
    input  comp_first,
    input  comp_second,
    input  comp_third,
    output ready
  );

endinterface

`default_nettype wire

// ===== rtl/core/rycc_out_if.sv =====
// ----------------------------------------------------------------------------
// rycc_out_if
// Pixel output channel: valid/ready handshake with three 8-bit components.
// ----------------------------------------------------------------------------
`default_nettype none

interface rycc_out_if;

  logic       valid;
  logic       ready;
  logic [7:0] out_first;
  logic [7:0] out_second;
  logic [7:0] out_third;

  modport source (
    output valid,
    output out_first,
    output out_second,
    output out_third,
    input  ready
  );

  modport sink (
    input  valid,
    input  out_first,
    input  out_second,
    input  out_third,
    output ready
  );

endinterface

`default_nettype wire

// ===== rtl/core/rycc_apb_regs.sv =====
// ----------------------------------------------------------------------------
// rycc_apb_regs
// APB register file holding the conversion direction.
// ----------------------------------------------------------------------------
`default_nettype none

module rycc_apb_regs
  import rycc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [DATA_W-1:0] pwdata_i,
  output logic [DATA_W-1:0] prdata_o,
  output logic              pready_o,
  output dir_e              dir_o
);

  dir_e dir_q;
  dir_e dir_d;
  logic hit_dir;
  logic wr_en;

  assign hit_dir  = (paddr_i[ADDR_W-1:2] == REG_DIRECTION);
  assign wr_en    = psel_i && penable_i && pwrite_i && pready_o;
  assign pready_o = 1'b1;

  always_comb begin
    dir_d = dir_q;
    if (wr_en && hit_dir) begin
      dir_d = dir_e'(pwdata_i[0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= DIR_FWD;
    end else begin
      dir_q <= dir_d;
    end
  end

  always_comb begin
    prdata_o = '0;
    if (hit_dir) begin
      prdata_o = {{(DATA_W-1){1'b0}}, dir_q};
    end
  end

  assign dir_o = dir_q;

endmodule

`default_nettype wire

// ===== rtl/core/rycc_front.sv =====
// ----------------------------------------------------------------------------
// rycc_front
// Stage 1: forms the three signed operands of a pixel word and registers
// them with the direction that applies to it.
// ----------------------------------------------------------------------------
`default_nettype none

module rycc_front
  import rycc_pkg::*;
(
  input  logic             clk_i,
  input  pipe_load_t       load_i,
  input  dir_e             dir_i,
  input  logic [PIX_W-1:0] comp_first_i,
  input  logic [PIX_W-1:0] comp_second_i,
  input  logic [PIX_W-1:0] comp_third_i,
  output opnd_t            opnd_o
);

  opnd_t opnd_d;
  opnd_t opnd_q;

  always_comb begin
    opnd_d.dir = dir_i;
    opnd_d.x0  = $signed({1'b0, comp_first_i});
    opnd_d.x1  = $signed({1'b0, comp_second_i});
    opnd_d.x2  = $signed({1'b0, comp_third_i});
    // Chroma is centred on zero before it meets the inverse coefficients.
    if (dir_i == DIR_INV) begin
      opnd_d.x1 = $signed({1'b0, comp_second_i}) - CHROMA_MID;
      opnd_d.x2 = $signed({1'b0, comp_third_i}) - CHROMA_MID;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.s1) begin
      opnd_q <= opnd_d;
    end
  end

  assign opnd_o = opnd_q;

endmodule

`default_nettype wire

// ===== rtl/core/rycc_mac.sv =====
// ----------------------------------------------------------------------------
// rycc_mac
// Stages 2 and 3: nine coefficient products, then one sum per component
// with the chroma offset added in the forward direction.
// ----------------------------------------------------------------------------
`default_nettype none

module rycc_mac
  import rycc_pkg::*;
#(
  parameter int unsigned COEF_FRAC_BITS = FRAC_BITS_DEF,
  localparam int unsigned SUM_W = COEF_FRAC_BITS + SUM_EXTRA
) (
  input  logic                    clk_i,
  input  pipe_load_t              load_i,
  input  opnd_t                   opnd_i,
  output logic signed [SUM_W-1:0] sum_o [3]
);

  localparam int unsigned F  = COEF_FRAC_BITS;
  localparam int unsigned CW = F + 2;

  localparam longint ONE  = longint'(1) << F;
  localparam longint HALF = ONE >> 1;

  // Coefficients rounded to the nearest unit of 2^-F.
  localparam longint K_Y_R  = ((longint'(299) << F) + 500) / 1000;
  localparam longint K_Y_G  = ((longint'(587) << F) + 500) / 1000;
  localparam longint K_Y_B  = ((longint'(114) << F) + 500) / 1000;
  localparam longint K_CB_R = ((longint'(168736) << F) + 500000) / 1000000;
  localparam longint K_CB_G = ((longint'(331264) << F) + 500000) / 1000000;
  localparam longint K_CR_G = ((longint'(418688) << F) + 500000) / 1000000;
  localparam longint K_CR_B = ((longint'(81312) << F) + 500000) / 1000000;
  localparam longint K_R_CR = ((longint'(1402) << F) + 500) / 1000;
  localparam longint K_G_CB = ((longint'(344136) << F) + 500000) / 1000000;
  localparam longint K_G_CR = ((longint'(714136) << F) + 500000) / 1000000;
  localparam longint K_B_CB = ((longint'(1772) << F) + 500) / 1000;

  localparam logic signed [SUM_W-1:0] CHROMA_BIAS = SUM_W'(longint'(128) << F);

  logic signed [CW-1:0]     coef   [3][3];
  logic signed [OPND_W-1:0] x      [3];
  logic signed [SUM_W-1:0]  prod_q [3][3];
  logic signed [SUM_W-1:0]  bias   [3];
  logic signed [SUM_W-1:0]  sum_q  [3];
  dir_e                     dir_q;

  assign x[0] = opnd_i.x0;
  assign x[1] = opnd_i.x1;
  assign x[2] = opnd_i.x2;

  always_comb begin
    case (opnd_i.dir)
      DIR_INV: begin
        coef[0][0] = CW'(ONE);
        coef[0][1] = '0;
        coef[0][2] = CW'(K_R_CR);
        coef[1][0] = CW'(ONE);
        coef[1][1] = CW'(-K_G_CB);
        coef[1][2] = CW'(-K_G_CR);
        coef[2][0] = CW'(ONE);
        coef[2][1] = CW'(K_B_CB);
        coef[2][2] = '0;
      end
      default: begin
        coef[0][0] = CW'(K_Y_R);
        coef[0][1] = CW'(K_Y_G);
        coef[0][2] = CW'(K_Y_B);
        coef[1][0] = CW'(-K_CB_R);
        coef[1][1] = CW'(-K_CB_G);
        coef[1][2] = CW'(HALF);
        coef[2][0] = CW'(HALF);
        coef[2][1] = CW'(-K_CR_G);
        coef[2][2] = CW'(-K_CR_B);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_i.s2) begin
      dir_q <= opnd_i.dir;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= SUM_W'(coef[r][c]) * SUM_W'(x[c]);
        end
      end
    end
  end

  // Only the forward chroma components carry the offset.
  always_comb begin
    bias[0] = '0;
    bias[1] = (dir_q == DIR_FWD) ? CHROMA_BIAS : '0;
    bias[2] = (dir_q == DIR_FWD) ? CHROMA_BIAS : '0;
  end

  always_ff @(posedge clk_i) begin
    if (load_i.s3) begin
      for (int r = 0; r < 3; r++) begin
        sum_q[r] <= prod_q[r][0] + prod_q[r][1] + prod_q[r][2] + bias[r];
      end
    end
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

// ===== rtl/core/rycc_round.sv =====
// ----------------------------------------------------------------------------
// rycc_round
// Stage 4: clamps each sum to the pixel range and rounds half up into the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rycc_round
  import rycc_pkg::*;
#(
  parameter int unsigned COEF_FRAC_BITS = FRAC_BITS_DEF,
  localparam int unsigned SUM_W = COEF_FRAC_BITS + SUM_EXTRA
) (
  input  logic                          clk_i,
  input  pipe_load_t                    load_i,
  input  logic signed [SUM_W-1:0]       sum_i [3],
  output logic [2:0][PIX_W-1:0]         pix_o
);

  localparam int unsigned F = COEF_FRAC_BITS;

  localparam logic signed [SUM_W-1:0] HALF_UNIT = SUM_W'(longint'(1) << (F - 1));
  localparam logic signed [SUM_W-1:0] TOP_LIMIT = SUM_W'(longint'(255) << F);

  logic [SUM_W-1:0]      rnd   [3];
  logic [2:0][PIX_W-1:0] pix_d;
  logic [2:0][PIX_W-1:0] pix_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rnd[r] = sum_i[r] + HALF_UNIT;
      if (sum_i[r][SUM_W-1]) begin
        pix_d[r] = '0;
      end else if (sum_i[r] > TOP_LIMIT) begin
        pix_d[r] = '1;
      end else begin
        pix_d[r] = rnd[r][F+PIX_W-1:F];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.s4) begin
      pix_q <= pix_d;
    end
  end

  assign pix_o = pix_q;

endmodule

`default_nettype wire

// ===== rtl/core/rgb_ycbcr_color_convert.sv =====
// ----------------------------------------------------------------------------
// rgb_ycbcr_color_convert
// Full-range JFIF colour space conversion, RGB to YCbCr or back, one pixel
// word per clock while in_i.ready is high, through a four-stage pipeline.
//
//   Channel   Dir   Handshake             Carries
//   in_i      in    valid / ready         comp_first, comp_second, comp_third
//   out_o     out   valid / ready         out_first, out_second, out_third
//   APB       in    psel/penable/pready   direction register at byte 0
//
// A word is accepted every cycle while in_i.ready is high; its result moves
// through the operand, product and sum registers into the output register,
// where out_o can take it. Reset empties the pipeline and selects the
// forward direction. Each stage holds its word while the one after it is full
// and stalled, so a stall on out_o reaches in_i only once all four stages fill.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb_ycbcr_color_convert_macros.svh"

module rgb_ycbcr_color_convert
  import rycc_pkg::*;
#(
  parameter int unsigned COEF_FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rycc_in_if.sink           in_i,
  rycc_out_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int unsigned SUM_W = COEF_FRAC_BITS + SUM_EXTRA;

  dir_e                    dir;
  pipe_load_t              load;
  opnd_t                   opnd_q;
  logic signed [SUM_W-1:0] sum   [3];
  logic [2:0][PIX_W-1:0]   pix;

  logic v1_q, v2_q, v3_q, v4_q;
  logic v1_d, v2_d, v3_d, v4_d;
  logic rdy1, rdy2, rdy3, rdy4;

  rycc_apb_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .dir_o     (dir)
  );

  // A stage may take a new word when it is empty or its word moves on.
  assign rdy4 = !v4_q || out_o.ready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign load.s1 = in_i.valid && rdy1;
  assign load.s2 = v1_q && rdy2;
  assign load.s3 = v2_q && rdy3;
  assign load.s4 = v3_q && rdy4;

  assign v1_d = rdy1 ? in_i.valid : v1_q;
  assign v2_d = rdy2 ? v1_q : v2_q;
  assign v3_d = rdy3 ? v2_q : v3_q;
  assign v4_d = rdy4 ? v3_q : v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
    end
  end

  rycc_front u_front (
    .clk_i         (clk_i),
    .load_i        (load),
    .dir_i         (dir),
    .comp_first_i  (in_i.comp_first),
    .comp_second_i (in_i.comp_second),
    .comp_third_i  (in_i.comp_third),
    .opnd_o        (opnd_q)
  );

  rycc_mac #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .load_i (load),
    .opnd_i (opnd_q),
    .sum_o  (sum)
  );

  rycc_round #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_round (
    .clk_i  (clk_i),
    .load_i (load),
    .sum_i  (sum),
    .pix_o  (pix)
  );

  assign in_i.ready       = rdy1;
  assign out_o.valid      = v4_q;
  assign out_o.out_first  = pix[0];
  assign out_o.out_second = pix[1];
  assign out_o.out_third  = pix[2];

  `RYCC_ASSERT_NEXT(a_accept_enters, in_i.valid && in_i.ready, v1_q, "accepted word missing from stage one")
  `RYCC_ASSERT_SAME(a_block_only_full, !in_i.ready, v1_q && v2_q && v3_q && v4_q, "input blocked with a bubble in the pipeline")
  `RYCC_ASSERT_NEXT(a_stage_one_holds, v1_q && !rdy2, v1_q && $stable(opnd_q), "stage one word changed while stalled")

endmodule

`default_nettype wire
